[hw/rtl/annexb_nal_start_code_splitter_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the Annex B start-code splitter
// Clocked on clk with arst_n as the disable condition of every property.
// -----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_START_CODE_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_START_CODE_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define ANSC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ANSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ansc_pkg.sv]
// -----------------------------------------------------------------------------
// Annex B start-code splitter package
// Shared result type, status codes and defaults.
// -----------------------------------------------------------------------------
package ansc_pkg;

	localparam int LENGTH_BITS_DEFAULT = 24;
	localparam int UNIT_LEN_W          = 24;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_SYNC = 2'd1;
	localparam logic [1:0] STATUS_SAT     = 2'd2;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	localparam logic [2:0] SC_SHORT = 3'd3;
	localparam logic [2:0] SC_LONG  = 3'd4;

	typedef struct packed {
		logic [UNIT_LEN_W-1:0] unit_length;
		logic [2:0]            start_code_length;
		logic [4:0]            unit_type;
	} ansc_desc_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		ansc_desc_t desc;
	} ansc_result_t;

endpackage

[hw/rtl/ansc_parser.sv]
// -----------------------------------------------------------------------------
// Annex B start-code parser
// Tracks sync, unit bytes and the byte window; closes a unit per start code and at stream end.
// -----------------------------------------------------------------------------
module ansc_parser #(
	parameter int LENGTH_BITS = ansc_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 stream_end,
	output ansc_pkg::ansc_result_t result
);
	import ansc_pkg::*;

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_UNIT = 2'd1;
	localparam logic [1:0] PH_HALT = 2'd2;

	logic [23:0]            recent_q, recent_d;
	logic [1:0]             phase_q, phase_d;
	logic [2:0]             sync_q, sync_d;
	logic [2:0]             code_len_q, code_len_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;
	logic [4:0]             hdr_type_q, hdr_type_d;
	logic                   hdr_pend_q, hdr_pend_d;

	logic                   sat;
	logic [2:0]             found;
	logic [LENGTH_BITS:0]   raw;
	logic [LENGTH_BITS:0]   len_cut;
	logic [4:0]             type_now;

	assign sat   = &count_q;
	assign found = (recent_q[23:16] == BYTE_ZERO) ? SC_LONG : SC_SHORT;
	assign raw   = {1'b0, count_q} + (LENGTH_BITS+1)'(1);
	assign len_cut = (raw >= (LENGTH_BITS+1)'(found)) ? raw - (LENGTH_BITS+1)'(found)
		: '0;
	assign type_now = hdr_pend_q ? data_byte[4:0] : hdr_type_q;

	always_comb begin
		recent_d   = recent_q;
		phase_d    = phase_q;
		sync_d     = sync_q;
		code_len_d = code_len_q;
		count_d    = count_q;
		hdr_type_d = hdr_type_q;
		hdr_pend_d = hdr_pend_q;
		result     = '0;
		if (accept) begin
			case (phase_q)
				PH_SYNC: begin
					if (stream_end) begin
						if (sync_q != 3'd0) begin
							phase_d       = PH_HALT;
							result.valid  = 1'b1;
							result.status = STATUS_NO_SYNC;
						end
					end else begin
						case (sync_q)
							3'd0, 3'd1: begin
								if (data_byte != BYTE_ZERO) begin
									phase_d       = PH_HALT;
									result.valid  = 1'b1;
									result.status = STATUS_NO_SYNC;
								end else begin
									sync_d = sync_q + 3'd1;
								end
							end
							3'd2: begin
								if (data_byte == BYTE_ONE) begin
									sync_d     = 3'd0;
									phase_d    = PH_UNIT;
									code_len_d = SC_SHORT;
									count_d    = '0;
									recent_d   = '1;
									hdr_type_d = '0;
									hdr_pend_d = 1'b1;
								end else if (data_byte != BYTE_ZERO) begin
									phase_d       = PH_HALT;
									result.valid  = 1'b1;
									result.status = STATUS_NO_SYNC;
								end else begin
									sync_d = 3'd3;
								end
							end
							3'd3: begin
								if (data_byte == BYTE_ONE) begin
									sync_d     = 3'd0;
									phase_d    = PH_UNIT;
									code_len_d = SC_LONG;
									count_d    = '0;
									recent_d   = '1;
									hdr_type_d = '0;
									hdr_pend_d = 1'b1;
								end else begin
									phase_d       = PH_HALT;
									result.valid  = 1'b1;
									result.status = STATUS_NO_SYNC;
								end
							end
							default: begin
								phase_d       = PH_HALT;
								result.valid  = 1'b1;
								result.status = STATUS_NO_SYNC;
							end
						endcase
					end
				end
				PH_UNIT: begin
					if (stream_end) begin
						// Flush the open unit and fall back to syncing on a new stream.
						result.valid                  = 1'b1;
						result.status                 = sat ? STATUS_SAT : STATUS_OK;
						result.desc.unit_type         = hdr_type_q;
						result.desc.start_code_length = code_len_q;
						result.desc.unit_length       = UNIT_LEN_W'(count_q);
						recent_d   = '1;
						phase_d    = PH_SYNC;
						sync_d     = 3'd0;
						code_len_d = 3'd0;
						count_d    = '0;
						hdr_type_d = '0;
						hdr_pend_d = 1'b0;
					end else if (data_byte == BYTE_ONE && recent_q[15:0] == 16'h0000) begin
						// Unless the count is saturated, the start code bytes already counted are taken back off.
						result.valid                  = 1'b1;
						result.status                 = sat ? STATUS_SAT : STATUS_OK;
						result.desc.unit_type         = type_now;
						result.desc.start_code_length = code_len_q;
						result.desc.unit_length       = sat ? UNIT_LEN_W'(count_q)
							: UNIT_LEN_W'(len_cut);
						phase_d    = PH_UNIT;
						code_len_d = found;
						count_d    = '0;
						recent_d   = '1;
						hdr_type_d = '0;
						hdr_pend_d = 1'b1;
					end else begin
						hdr_type_d = type_now;
						hdr_pend_d = 1'b0;
						recent_d   = {recent_q[15:0], data_byte};
						if (!sat) begin
							count_d = count_q + LENGTH_BITS'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '1;
			phase_q    <= PH_SYNC;
			sync_q     <= 3'd0;
			code_len_q <= 3'd0;
			count_q    <= '0;
			hdr_type_q <= 5'd0;
			hdr_pend_q <= 1'b0;
		end else begin
			recent_q   <= recent_d;
			phase_q    <= phase_d;
			sync_q     <= sync_d;
			code_len_q <= code_len_d;
			count_q    <= count_d;
			hdr_type_q <= hdr_type_d;
			hdr_pend_q <= hdr_pend_d;
		end
	end

endmodule

[hw/rtl/ansc_out_buf.sv]
// -----------------------------------------------------------------------------
// Annex B splitter result queue
// Two-entry output queue that decouples the parser from the result sink.
// -----------------------------------------------------------------------------
module ansc_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ansc_pkg::ansc_result_t push_result,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ansc_pkg::ansc_desc_t   out_desc,
	output logic [1:0]             out_status
);
	import ansc_pkg::*;

	logic       v0_q, v1_q;
	ansc_desc_t d0_q, d1_q;
	logic [1:0] s0_q, s1_q;
	logic       push, pop;

	assign push       = push_result.valid;
	assign pop        = v0_q && out_ready;
	assign full       = v1_q;
	assign out_valid  = v0_q;
	assign out_desc   = d0_q;
	assign out_status = s0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (pop) begin
				v0_q <= v1_q || push;
				v1_q <= v1_q && push;
			end else if (push) begin
				v0_q <= 1'b1;
				v1_q <= v0_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				d0_q <= d1_q;
				s0_q <= s1_q;
				d1_q <= push_result.desc;
				s1_q <= push_result.status;
			end else begin
				d0_q <= push_result.desc;
				s0_q <= push_result.status;
			end
		end else if (push) begin
			if (v0_q) begin
				d1_q <= push_result.desc;
				s1_q <= push_result.status;
			end else begin
				d0_q <= push_result.desc;
				s0_q <= push_result.status;
			end
		end
	end

endmodule

[hw/rtl/annexb_nal_start_code_splitter.sv]
// -----------------------------------------------------------------------------
// Annex B NAL start-code splitter
// Splits an H.264 Annex B byte stream into NAL unit descriptors.
// -----------------------------------------------------------------------------
//  Channel  | Side   | Content
//  ---------+--------+---------------------------------------------------------
//  s_*      | in     | tdata: stream byte; tlast: end of stream
//  m_*      | out    | tdata: unit type, start code length, unit length; tuser: status
//
// One byte item is taken per clock while s_tready is high; its result item, if any, is
// registered into a two-entry result queue after the parser and shown on m_* from its head;
// s_tready is low only while both entries hold results that are not yet taken.
// Reset clears the sync state, the byte window, the counters and the queue.
// -----------------------------------------------------------------------------
module annexb_nal_start_code_splitter #(
	parameter int LENGTH_BITS = ansc_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [4:0] unit_type, [7:5] start_code_length,
	                               // [31:8] unit_length
	output logic [1:0]  m_tuser    // [1:0] status
);
	import ansc_pkg::*;

	ansc_result_t result;
	ansc_desc_t   desc;
	logic         full;
	logic         accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && !full;

	ansc_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.stream_end(s_tlast),
		.result    (result)
	);

	ansc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_result(result),
		.full       (full),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_desc   (desc),
		.out_status (m_tuser)
	);

	assign m_tdata = {desc.unit_length, desc.start_code_length, desc.unit_type};

endmodule

[hw/rtl/ansc_checker.sv]
// -----------------------------------------------------------------------------
// Annex B splitter port checker
// Watches the top-level ports for consistent result items.
// -----------------------------------------------------------------------------
`include "annexb_nal_start_code_splitter_macros.svh"

module ansc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import ansc_pkg::*;

	logic err_item;
	logic ok_item;
	logic sc_legal;
	logic stalled;

	assign err_item = m_tvalid && m_tuser == STATUS_NO_SYNC;
	assign ok_item  = m_tvalid && m_tuser == STATUS_OK;
	assign sc_legal = m_tdata[7:5] == SC_SHORT || m_tdata[7:5] == SC_LONG;
	assign stalled  = m_tvalid && !m_tready;

	// An error item carries no descriptor.
	`ANSC_ASSERT(a_err_empty, err_item, m_tdata == 32'd0, "error item with nonzero data")

	// A good unit opened with a three- or four-byte start code.
	`ANSC_ASSERT(a_sc_len, ok_item, sc_legal, "bad start code length")

	// The error item is the last one the block ever gives before reset.
	`ANSC_ASSERT_NEXT(a_err_last, err_item && m_tready, !m_tvalid, "item after sync error")

	// A stalled result item holds.
	`ANSC_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable({m_tdata, m_tuser}), "stalled item changed")

endmodule

bind annexb_nal_start_code_splitter ansc_checker u_ansc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
